// ===== design/three_angle_point_rotation_assert.svh =====
// Assertion macros shared by the rotation pipeline.
`ifndef THREE_ANGLE_POINT_ROTATION_ASSERT_SVH
`define THREE_ANGLE_POINT_ROTATION_ASSERT_SVH

`ifndef SYNTH
`define TAPR_ASSERT_NOW(lbl, clk_s, rst_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error("%m: check failed");
`define TAPR_ASSERT_AFTER(lbl, clk_s, rst_s, ante, n, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> ##n (cons)) \
        else $error("%m: check failed");
`else
`define TAPR_ASSERT_NOW(lbl, clk_s, rst_s, ante, cons)
`define TAPR_ASSERT_AFTER(lbl, clk_s, rst_s, ante, n, cons)
`endif

`endif

// ===== design/tapr_pkg.sv =====
package tapr_pkg;

    localparam int COORD_WIDTH             = 32;
    localparam int ANGLE_WIDTH             = 16;
    localparam int ROTATION_STAGES_DEFAULT = 18;
    localparam int GUARD_BITS              = 8;
    localparam int HEAD_BITS               = 3;
    localparam int ACC_WIDTH               = COORD_WIDTH + GUARD_BITS + HEAD_BITS;
    localparam int TURN_WIDTH              = 32;
    localparam int ATAN_LEN                = 32;
    localparam int GAIN_FRAC               = 30;
    localparam logic [GAIN_FRAC-1:0] INV_GAIN = 30'd652032874;

    localparam int CFG_INDEX_WIDTH = 2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_FIRST_ANGLE  = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_SECOND_ANGLE = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_THIRD_ANGLE  = 2'd2;

    typedef logic signed [ACC_WIDTH-1:0]  acc_t;
    typedef logic signed [TURN_WIDTH-1:0] turn_t;
    typedef logic [ANGLE_WIDTH-1:0]       angle_t;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] in_x;
        logic signed [COORD_WIDTH-1:0] in_y;
        logic signed [COORD_WIDTH-1:0] in_z;
        logic                          in_last;
    } item_t;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] out_x;
        logic signed [COORD_WIDTH-1:0] out_y;
        logic signed [COORD_WIDTH-1:0] out_z;
        logic                          out_last;
    } result_t;

    // The pair (a, b) is rotated; c rides along untouched.
    typedef struct packed {
        acc_t a;
        acc_t b;
        acc_t c;
        logic last;
    } vec_t;

    typedef struct packed {
        vec_t  vec;
        turn_t z;
    } cell_word_t;

    // Arctangent of 2^-i in units of 2^-32 turn, rounded.
    function automatic logic [TURN_WIDTH-1:0] atan_turn(input int unsigned idx);
        logic [TURN_WIDTH-1:0] val;
        case (idx)
            0:  val = 32'h2000_0000;
            1:  val = 32'h12E4_051E;
            2:  val = 32'h09FB_385B;
            3:  val = 32'h0511_11D4;
            4:  val = 32'h028B_0D43;
            5:  val = 32'h0145_D7E1;
            6:  val = 32'h00A2_F61E;
            7:  val = 32'h0051_7C55;
            8:  val = 32'h0028_BE53;
            9:  val = 32'h0014_5F2F;
            10: val = 32'h000A_2F98;
            11: val = 32'h0005_17CC;
            12: val = 32'h0002_8BE6;
            13: val = 32'h0001_45F3;
            14: val = 32'h0000_A2FA;
            15: val = 32'h0000_517D;
            16: val = 32'h0000_28BE;
            17: val = 32'h0000_145F;
            18: val = 32'h0000_0A30;
            19: val = 32'h0000_0518;
            20: val = 32'h0000_028C;
            21: val = 32'h0000_0146;
            22: val = 32'h0000_00A3;
            23: val = 32'h0000_0051;
            24: val = 32'h0000_0029;
            25: val = 32'h0000_0014;
            26: val = 32'h0000_000A;
            27: val = 32'h0000_0005;
            28: val = 32'h0000_0003;
            29: val = 32'h0000_0001;
            30: val = 32'h0000_0001;
            default: val = 32'h0000_0000;
        endcase
        return val;
    endfunction

endpackage

// ===== design/three_angle_point_rotation.sv =====
// Channel   Handshake                    Word
// --------  ---------------------------  ---------------------------------------
// item      start high, busy low         item_t: in_x, in_y, in_z, in_last
// result    done high for one cycle      result_t: out_x, out_y, out_z, out_last
// config    cfg_valid and cfg_ready      cfg_index selects the angle, cfg_data
//
// A new point is taken in every cycle; busy stays low.
// Each point passes through the three rotators in turn and then the result register; each
// rotator is a pre-rotation, one CORDIC cell per stage and a four-stage gain multiplier.
// Reset clears only the valid bits and the angle registers, which read zero after reset.
// The result is shown for one cycle and cannot be held off by the receiver.
`include "three_angle_point_rotation_assert.svh"

module three_angle_point_rotation #(
    parameter int ROTATION_STAGES = tapr_pkg::ROTATION_STAGES_DEFAULT
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  tapr_pkg::item_t                        item,
    output logic                                   done,
    output tapr_pkg::result_t                      result,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [tapr_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
    input  logic [tapr_pkg::ANGLE_WIDTH-1:0]       cfg_data
);
    import tapr_pkg::*;

    localparam int CELLS       = (ROTATION_STAGES < ATAN_LEN) ? ROTATION_STAGES : ATAN_LEN;
    localparam int ROT_LATENCY = CELLS + 5;
    localparam int LATENCY     = 3 * ROT_LATENCY + 1;
    localparam acc_t ROUND_HALF = acc_t'(1 << (GUARD_BITS - 1));
    localparam acc_t COORD_MAX  = acc_t'({1'b0, {(COORD_WIDTH-1){1'b1}}});
    localparam acc_t COORD_MIN  = -COORD_MAX - acc_t'(1);

    angle_t  first_angle_reg;
    angle_t  first_angle_next;
    angle_t  second_angle_reg;
    angle_t  second_angle_next;
    angle_t  third_angle_reg;
    angle_t  third_angle_next;

    logic    take;
    vec_t    load_vec;
    logic    rot0_valid;
    vec_t    rot0_vec;
    vec_t    rot1_in;
    logic    rot1_valid;
    vec_t    rot1_vec;
    vec_t    rot2_in;
    logic    rot2_valid;
    vec_t    rot2_vec;

    logic    done_reg;
    result_t result_reg;
    result_t result_next;

    function automatic logic signed [COORD_WIDTH-1:0] round_sat(input acc_t v);
        acc_t t;
        acc_t s;
        t = v + ROUND_HALF;
        s = t >>> GUARD_BITS;
        if (s > COORD_MAX)
        begin
            s = COORD_MAX;
        end
        else if (s < COORD_MIN)
        begin
            s = COORD_MIN;
        end
        return s[COORD_WIDTH-1:0];
    endfunction

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign take      = start && !busy;

    always_comb
    begin
        first_angle_next  = first_angle_reg;
        second_angle_next = second_angle_reg;
        third_angle_next  = third_angle_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_FIRST_ANGLE:  first_angle_next  = cfg_data;
                REG_SECOND_ANGLE: second_angle_next = cfg_data;
                REG_THIRD_ANGLE:  third_angle_next  = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_angle_reg  <= '0;
            second_angle_reg <= '0;
            third_angle_reg  <= '0;
            done_reg         <= 1'b0;
        end
        else
        begin
            first_angle_reg  <= first_angle_next;
            second_angle_reg <= second_angle_next;
            third_angle_reg  <= third_angle_next;
            done_reg         <= rot2_valid;
        end
    end

    always_comb
    begin
        load_vec.a    = acc_t'(item.in_x) <<< GUARD_BITS;
        load_vec.b    = acc_t'(item.in_y) <<< GUARD_BITS;
        load_vec.c    = acc_t'(item.in_z) <<< GUARD_BITS;
        load_vec.last = item.in_last;
    end

    tapr_rotator #(
        .STAGES(ROTATION_STAGES)
    ) u_rot_first (
        .clk        (clk),
        .rst_n      (rst_n),
        .angle      (first_angle_reg),
        .head_valid (take),
        .head_word  (load_vec),
        .tail_valid (rot0_valid),
        .tail_word  (rot0_vec)
    );

    // The second rotation turns the (z, y) plane, so z takes the first axis.
    always_comb
    begin
        rot1_in.a    = rot0_vec.c;
        rot1_in.b    = rot0_vec.b;
        rot1_in.c    = rot0_vec.a;
        rot1_in.last = rot0_vec.last;
    end

    tapr_rotator #(
        .STAGES(ROTATION_STAGES)
    ) u_rot_second (
        .clk        (clk),
        .rst_n      (rst_n),
        .angle      (second_angle_reg),
        .head_valid (rot0_valid),
        .head_word  (rot1_in),
        .tail_valid (rot1_valid),
        .tail_word  (rot1_vec)
    );

    always_comb
    begin
        rot2_in.a    = rot1_vec.c;
        rot2_in.b    = rot1_vec.b;
        rot2_in.c    = rot1_vec.a;
        rot2_in.last = rot1_vec.last;
    end

    tapr_rotator #(
        .STAGES(ROTATION_STAGES)
    ) u_rot_third (
        .clk        (clk),
        .rst_n      (rst_n),
        .angle      (third_angle_reg),
        .head_valid (rot1_valid),
        .head_word  (rot2_in),
        .tail_valid (rot2_valid),
        .tail_word  (rot2_vec)
    );

    always_comb
    begin
        result_next.out_x    = round_sat(rot2_vec.a);
        result_next.out_y    = round_sat(rot2_vec.b);
        result_next.out_z    = round_sat(rot2_vec.c);
        result_next.out_last = rot2_vec.last;
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    `TAPR_ASSERT_AFTER(result_follows_item, clk, rst_n, take, LATENCY, done)
    `TAPR_ASSERT_AFTER(no_spurious_result, clk, rst_n, !take, LATENCY, !done)
    `TAPR_ASSERT_AFTER(last_flag_kept, clk, rst_n, take, LATENCY,
        result.out_last == $past(item.in_last, LATENCY))

endmodule

// ===== design/tapr_cordic_cell.sv =====
`include "three_angle_point_rotation_assert.svh"

module tapr_cordic_cell #(
    parameter int STAGE = 0
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   head_valid,
    input  tapr_pkg::cell_word_t   head_word,
    output logic                   tail_valid,
    output tapr_pkg::cell_word_t   tail_word
);
    import tapr_pkg::*;

    localparam turn_t ATAN_STEP = turn_t'(atan_turn(STAGE));

    acc_t       delta_a;
    acc_t       delta_b;
    logic       valid_reg;
    cell_word_t word_reg;
    cell_word_t word_next;

    always_comb
    begin
        delta_a   = head_word.vec.b >>> STAGE;
        delta_b   = head_word.vec.a >>> STAGE;
        word_next = head_word;
        if (!head_word.z[TURN_WIDTH-1])
        begin
            word_next.vec.a = head_word.vec.a - delta_a;
            word_next.vec.b = head_word.vec.b + delta_b;
            word_next.z     = head_word.z - ATAN_STEP;
        end
        else
        begin
            word_next.vec.a = head_word.vec.a + delta_a;
            word_next.vec.b = head_word.vec.b - delta_b;
            word_next.z     = head_word.z + ATAN_STEP;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= head_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign tail_valid = valid_reg;
    assign tail_word  = word_reg;

    // The residual angle never leaves the range of plus or minus a quarter turn.
    `TAPR_ASSERT_NOW(residual_in_range, clk, rst_n, head_valid,
        head_word.z[TURN_WIDTH-1] == head_word.z[TURN_WIDTH-2])

endmodule

// ===== design/tapr_gain.sv =====
`include "three_angle_point_rotation_assert.svh"

module tapr_gain (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             head_valid,
    input  tapr_pkg::vec_t   head_word,
    output logic             tail_valid,
    output tapr_pkg::vec_t   tail_word
);
    import tapr_pkg::*;

    localparam int GAIN_STAGES = 4;
    localparam int HI_WIDTH    = ACC_WIDTH - GAIN_FRAC;
    localparam int HI_PROD     = HI_WIDTH + GAIN_FRAC;
    localparam int LO_PROD     = 2 * GAIN_FRAC;
    localparam int ROUND_WIDTH = LO_PROD - GAIN_FRAC + 1;
    localparam logic [LO_PROD:0] PROD_HALF =
        {{ROUND_WIDTH{1'b0}}, 1'b1, {(GAIN_FRAC-1){1'b0}}};

    typedef struct packed {
        acc_t       c;
        logic       last;
        logic [1:0] neg;
    } gain_side_t;

    logic [GAIN_STAGES-1:0] valid_reg;
    gain_side_t             side_reg [0:GAIN_STAGES-1];
    gain_side_t             side_next;

    acc_t                   lane_in [0:1];
    logic [ACC_WIDTH-1:0]   mag_next [0:1];
    logic [ACC_WIDTH-1:0]   mag_reg [0:1];
    logic [HI_PROD-1:0]     hi_prod_next [0:1];
    logic [HI_PROD-1:0]     hi_prod_reg [0:1];
    logic [LO_PROD-1:0]     lo_prod_next [0:1];
    logic [LO_PROD-1:0]     lo_prod_reg [0:1];
    logic [LO_PROD:0]       rounded [0:1];
    logic [ACC_WIDTH:0]     sum [0:1];
    logic [ACC_WIDTH-1:0]   scaled_next [0:1];
    logic [ACC_WIDTH-1:0]   scaled_reg [0:1];
    acc_t                   out_next [0:1];
    acc_t                   out_reg [0:1];

    assign lane_in[0] = head_word.a;
    assign lane_in[1] = head_word.b;

    always_comb
    begin
        side_next.c    = head_word.c;
        side_next.last = head_word.last;
        side_next.neg  = {lane_in[1][ACC_WIDTH-1], lane_in[0][ACC_WIDTH-1]};
        for (int l = 0; l < 2; l++)
        begin
            mag_next[l] = lane_in[l][ACC_WIDTH-1] ? unsigned'(-lane_in[l])
                                                  : unsigned'(lane_in[l]);
            hi_prod_next[l] = HI_PROD'(mag_reg[l][ACC_WIDTH-1:GAIN_FRAC])
                              * HI_PROD'(INV_GAIN);
            lo_prod_next[l] = LO_PROD'(mag_reg[l][GAIN_FRAC-1:0]) * LO_PROD'(INV_GAIN);
            rounded[l]      = {1'b0, lo_prod_reg[l]} + PROD_HALF;
            sum[l]          = (ACC_WIDTH+1)'(hi_prod_reg[l])
                              + (ACC_WIDTH+1)'(rounded[l][LO_PROD:GAIN_FRAC]);
            scaled_next[l]  = sum[l][ACC_WIDTH-1:0];
            out_next[l]     = side_reg[2].neg[l] ? -acc_t'(scaled_reg[l])
                                                 : acc_t'(scaled_reg[l]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[GAIN_STAGES-2:0], head_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        side_reg[0] <= side_next;
        for (int s = 1; s < GAIN_STAGES; s++)
        begin
            side_reg[s] <= side_reg[s-1];
        end
        for (int l = 0; l < 2; l++)
        begin
            mag_reg[l]     <= mag_next[l];
            hi_prod_reg[l] <= hi_prod_next[l];
            lo_prod_reg[l] <= lo_prod_next[l];
            scaled_reg[l]  <= scaled_next[l];
            out_reg[l]     <= out_next[l];
        end
    end

    assign tail_valid     = valid_reg[GAIN_STAGES-1];
    assign tail_word.a    = out_reg[0];
    assign tail_word.b    = out_reg[1];
    assign tail_word.c    = side_reg[GAIN_STAGES-1].c;
    assign tail_word.last = side_reg[GAIN_STAGES-1].last;

    `TAPR_ASSERT_AFTER(gain_latency, clk, rst_n, head_valid, 4, tail_valid)

endmodule

// ===== design/tapr_rotator.sv =====
module tapr_rotator #(
    parameter int STAGES = tapr_pkg::ROTATION_STAGES_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  tapr_pkg::angle_t  angle,
    input  logic              head_valid,
    input  tapr_pkg::vec_t    head_word,
    output logic              tail_valid,
    output tapr_pkg::vec_t    tail_word
);
    import tapr_pkg::*;

    localparam int CELLS = (STAGES < ATAN_LEN) ? STAGES : ATAN_LEN;
    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;
    localparam logic [TURN_WIDTH-1:0] EIGHTH_TURN = {3'b001, {(TURN_WIDTH-3){1'b0}}};

    logic [TURN_WIDTH-1:0] ang_full;
    logic [TURN_WIDTH-1:0] ang_shifted;
    logic [1:0]            quad;
    logic [TURN_WIDTH-1:0] resid;

    logic       pre_valid_reg;
    cell_word_t pre_word_reg;
    cell_word_t pre_word_next;

    logic [CELLS:0] cell_valid;
    cell_word_t     cell_word [0:CELLS];

    // The angle is folded to within an eighth turn by a quarter-turn pre-rotation.
    always_comb
    begin
        ang_full    = {angle, {(TURN_WIDTH-ANGLE_WIDTH){1'b0}}};
        ang_shifted = ang_full + EIGHTH_TURN;
        quad        = ang_shifted[TURN_WIDTH-1 -: 2];
        resid       = ang_full - {quad, {(TURN_WIDTH-2){1'b0}}};
        pre_word_next     = '0;
        pre_word_next.z   = turn_t'(resid);
        pre_word_next.vec = head_word;
        case (quad)
            QUAD_0:
            begin
                pre_word_next.vec.a = head_word.a;
                pre_word_next.vec.b = head_word.b;
            end
            QUAD_1:
            begin
                pre_word_next.vec.a = -head_word.b;
                pre_word_next.vec.b = head_word.a;
            end
            QUAD_2:
            begin
                pre_word_next.vec.a = -head_word.a;
                pre_word_next.vec.b = -head_word.b;
            end
            QUAD_3:
            begin
                pre_word_next.vec.a = head_word.b;
                pre_word_next.vec.b = -head_word.a;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pre_valid_reg <= 1'b0;
        end
        else
        begin
            pre_valid_reg <= head_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        pre_word_reg <= pre_word_next;
    end

    assign cell_valid[0] = pre_valid_reg;
    assign cell_word[0]  = pre_word_reg;

    for (genvar k = 0; k < CELLS; k++)
    begin : g_cell
        tapr_cordic_cell #(
            .STAGE(k)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .head_valid (cell_valid[k]),
            .head_word  (cell_word[k]),
            .tail_valid (cell_valid[k+1]),
            .tail_word  (cell_word[k+1])
        );
    end

    tapr_gain u_gain (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (cell_valid[CELLS]),
        .head_word  (cell_word[CELLS].vec),
        .tail_valid (tail_valid),
        .tail_word  (tail_word)
    );

endmodule
